### rtl/core/sads_pkg.sv
// Shared types, sizes and field positions for the two-stack shared store.
`timescale 1ns / 1ps

package sads_pkg;

  // Store depth and derived widths
  localparam int DEPTH  = 256;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  // Input tdata: command, elem_x, elem_y (stack_sel travels in tuser)
  localparam int IN_CMD_LO  = 0;
  localparam int IN_X_LO    = 2;
  localparam int IN_Y_LO    = IN_X_LO + WORD_W;
  localparam int IN_USED_W  = IN_Y_LO + WORD_W;
  localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata: status, out_x, out_y, length, is_empty, is_full
  localparam int OUT_ST_LO   = 0;
  localparam int OUT_X_LO    = 2;
  localparam int OUT_Y_LO    = OUT_X_LO + WORD_W;
  localparam int OUT_LEN_LO  = OUT_Y_LO + WORD_W;
  localparam int OUT_EMPTY   = OUT_LEN_LO + LEN_W;
  localparam int OUT_FULL    = OUT_EMPTY + 1;
  localparam int OUT_USED_W  = OUT_FULL + 1;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;      // run the accepted transaction against the store
    logic load_out;  // move the finished result into the output register
  } dp_ctrl_t;

endpackage

### rtl/core/sads_ctrl.sv
// Controller state machine: input acceptance and output register valid.
`timescale 1ns / 1ps

module sads_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output sads_pkg::dp_ctrl_t ctrl
);

  typedef enum logic {
    S_IDLE,
    S_DELIVER
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    ctrl.exec     = 1'b0;
    ctrl.load_out = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctrl.exec = 1'b1;
          state_nxt = S_DELIVER;
        end
      end
      S_DELIVER: begin
        if (out_free) begin
          ctrl.load_out = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### rtl/core/sads_datapath.sv
// Datapath: stack counts, shared element memory, result and output registers.
`timescale 1ns / 1ps

module sads_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sads_pkg::dp_ctrl_t               ctrl,
  input  logic [sads_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,
  output logic [sads_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int AW = sads_pkg::ADDR_W;
  localparam int LW = sads_pkg::LEN_W;
  localparam int WW = sads_pkg::WORD_W;

  logic [2*WW-1:0] mem [sads_pkg::DEPTH];

  logic [LW-1:0] lower_r, lower_nxt;
  logic [LW-1:0] upper_r, upper_nxt;

  sads_pkg::cmd_t    cmd;
  logic              sel;
  logic [WW-1:0]     ex, ey;
  logic [LW-1:0]     cur_cnt;
  logic [LW:0]       used, used_nxt;
  logic              full_now;
  sads_pkg::status_t status;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_idx, rd_idx;
  logic [LW-1:0]     top_up;

  // result of the transaction in flight
  sads_pkg::status_t status_r;
  logic [LW-1:0]     len_r;
  logic              empty_r, full_r, rd_ok_r;
  logic [2*WW-1:0]   rd_data_r;

  // output register
  logic [sads_pkg::OUT_DATA_W-1:0] out_r, out_nxt;

  assign cmd      = sads_pkg::cmd_t'(in_tdata[sads_pkg::IN_CMD_LO +: 2]);
  assign sel      = in_tuser;
  assign ex       = in_tdata[sads_pkg::IN_X_LO +: WW];
  assign ey       = in_tdata[sads_pkg::IN_Y_LO +: WW];
  assign cur_cnt  = sel ? upper_r : lower_r;
  assign used     = {1'b0, lower_r} + {1'b0, upper_r};
  assign full_now = (used >= (LW+1)'(sads_pkg::DEPTH));
  // top entry of the upper stack sits at DEPTH - count
  assign top_up   = LW'(sads_pkg::DEPTH) - upper_r;

  always_comb begin
    lower_nxt = lower_r;
    upper_nxt = upper_r;
    status    = sads_pkg::STAT_OK;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    wr_idx    = sel ? (AW'(sads_pkg::DEPTH - 1) - upper_r[AW-1:0]) : lower_r[AW-1:0];
    rd_idx    = sel ? top_up[AW-1:0] : (lower_r[AW-1:0] - AW'(1));
    unique case (cmd)
      sads_pkg::CMD_PUSH: begin
        if (full_now) begin
          status = sads_pkg::STAT_FULL;
        end else begin
          wr_en = 1'b1;
          if (sel) upper_nxt = upper_r + LW'(1);
          else     lower_nxt = lower_r + LW'(1);
        end
      end
      sads_pkg::CMD_POP, sads_pkg::CMD_PEEK: begin
        if (cur_cnt == '0) begin
          status = sads_pkg::STAT_EMPTY;
        end else begin
          rd_en = 1'b1;
          if (cmd == sads_pkg::CMD_POP) begin
            if (sel) upper_nxt = upper_r - LW'(1);
            else     lower_nxt = lower_r - LW'(1);
          end
        end
      end
      sads_pkg::CMD_CLEAR: begin
        if (sel) upper_nxt = '0;
        else     lower_nxt = '0;
      end
      default: ;
    endcase
  end

  assign used_nxt = {1'b0, lower_nxt} + {1'b0, upper_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= '0;
    end else if (ctrl.exec) begin
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
    end
  end

  // element memory: x in the low word, y in the high word
  always_ff @(posedge clk) begin
    if (ctrl.exec && wr_en) mem[wr_idx] <= {ey, ex};
    if (ctrl.exec && rd_en) rd_data_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      status_r <= status;
      len_r    <= sel ? upper_nxt : lower_nxt;
      empty_r  <= sel ? (upper_nxt == '0) : (lower_nxt == '0);
      full_r   <= (used_nxt >= (LW+1)'(sads_pkg::DEPTH));
      rd_ok_r  <= rd_en;
    end
  end

  // packed result word, padding bits zero
  always_comb begin
    out_nxt                                 = '0;
    out_nxt[sads_pkg::OUT_ST_LO +: 2]       = status_r;
    out_nxt[sads_pkg::OUT_X_LO +: WW]       = rd_ok_r ? rd_data_r[WW-1:0] : '0;
    out_nxt[sads_pkg::OUT_Y_LO +: WW]       = rd_ok_r ? rd_data_r[2*WW-1:WW] : '0;
    out_nxt[sads_pkg::OUT_LEN_LO +: LW]     = len_r;
    out_nxt[sads_pkg::OUT_EMPTY]            = empty_r;
    out_nxt[sads_pkg::OUT_FULL]             = full_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_tdata = out_r;

endmodule

### rtl/core/shared_array_dual_stack_top.sv
// Top level of the two-stack shared store: controller plus datapath.
// An accepted transaction updates the counts and result registers; its result then moves into the
// output register once that register is free. The controller holds one transaction at a time and
// the memory read for pop/peek is registered, so accept and delivery are separate controller states.
// A new transaction is taken while an earlier result still waits in the output register.
// Reset (rst_n low, synchronous): both stack counts clear and the output is empty; the element
// memory keeps its contents and needs no clearing pass.
`timescale 1ns / 1ps

module shared_array_dual_stack_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input transactions
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sads_pkg::IN_DATA_W-1:0]   in_tdata,  // command[1:0], elem_x[33:2], elem_y[65:34]
  input  logic                             in_tuser,  // stack_sel
  // result transactions
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sads_pkg::OUT_DATA_W-1:0]  out_tdata  // status[1:0], out_x[33:2], out_y[65:34],
                                                      // length[74:66], is_empty[75], is_full[76]
);

  // command bundle from the controller to the datapath
  sads_pkg::dp_ctrl_t ctrl;

  // controller: accepts one transaction, then waits until the output register is free
  sads_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctrl       (ctrl)
  );

  // datapath: counts, shared memory, result and output registers
  sads_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata)
  );

endmodule

### rtl/core/sads_checker.sv
// Port-level checker for the two-stack shared store and its bind to the top level.
`timescale 1ns / 1ps

module sads_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sads_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // a held result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transaction");

  // one transaction in flight: no back-to-back accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // empty flag agrees with the reported length
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[sads_pkg::OUT_EMPTY] ==
                    (out_tdata[sads_pkg::OUT_LEN_LO +: sads_pkg::LEN_W] == '0)))
    else $error("is_empty disagrees with length");

  // a refused push only happens on a full store
  a_full_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[sads_pkg::OUT_ST_LO +: 2] == sads_pkg::STAT_FULL)
    |-> out_tdata[sads_pkg::OUT_FULL])
    else $error("full status without full flag");

  // refused pop or peek returns a zero element
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[sads_pkg::OUT_ST_LO +: 2] == sads_pkg::STAT_EMPTY)
    |-> (out_tdata[sads_pkg::OUT_X_LO +: 2*sads_pkg::WORD_W] == '0))
    else $error("nonzero data on empty status");

endmodule

bind shared_array_dual_stack_top sads_checker u_sads_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/shared_array_dual_stack_top_test.sv
// Testbench for the two-stack shared store: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps

module shared_array_dual_stack_top_test;
  import sads_pkg::*;

  // Slowest run: ~1500 transactions, each with random idle on the sender, the pass through the block
  // and random stalls on the receiver, plus drain pauses. Taken ~8x over.
  localparam int CYCLE_LIMIT  = 400000;
  // Result passes the result registers, then the output register once it is free; spare cycles at the end.
  localparam int TAIL_CYCLES  = 8;
  localparam int PHASE_ITEMS  = 60;
  localparam int IDLE_SHUFFLE = 64;

  // One expected result, field by field
  typedef struct {
    status_t              status;
    logic [WORD_W-1:0]    x;
    logic [WORD_W-1:0]    y;
    logic [LEN_W-1:0]     length;
    logic                 is_empty;
    logic                 is_full;
  } stack_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;   // command, elem_x, elem_y (lowest bit up)
  logic                   in_tuser = 1'b0; // stack_sel
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;       // status, out_x, out_y, length, is_empty, is_full

  // Predictor state: its own copy of the store and both counts
  logic [2*WORD_W-1:0]    model_store [DEPTH];
  int unsigned            model_lower = 0;
  int unsigned            model_upper = 0;
  stack_result_t          expected_q[$];

  int unsigned            error_count = 0;
  int unsigned            cycle_count = 0;
  // When set, that side runs back to back without idle cycles
  bit                     tx_no_idle = 1'b0;
  bit                     rx_no_idle = 1'b0;
  int unsigned            rx_stall = 0;

  shared_array_dual_stack_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hang or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** shared_array_dual_stack_top: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(bit no_idle);
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  // Re-pick idle behavior; about a quarter of the stretches run with no idling on a side
  function automatic void shuffle_idle();
    tx_no_idle = ($urandom_range(0, 3) == 0);
    rx_no_idle = ($urandom_range(0, 3) == 0);
  endfunction

  // Applies one transaction to the predictor state and returns the result it must give
  function automatic stack_result_t apply_stack_op(cmd_t cmd, logic sel,
                                                   logic [WORD_W-1:0] x, logic [WORD_W-1:0] y);
    stack_result_t r;
    int unsigned   cnt;
    int unsigned   idx;
    int unsigned   len;
    r.status = STAT_OK;
    r.x = '0;
    r.y = '0;
    case (cmd)
      CMD_PUSH: begin
        if (model_lower + model_upper >= DEPTH) begin
          r.status = STAT_FULL;
        end else if (sel == 1'b0) begin
          model_store[model_lower] = {y, x};
          model_lower++;
        end else begin
          model_store[DEPTH - 1 - model_upper] = {y, x};
          model_upper++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        cnt = sel ? model_upper : model_lower;
        if (cnt == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // lower top sits just below its count, upper top at DEPTH - count
          idx = sel ? DEPTH - model_upper : model_lower - 1;
          {r.y, r.x} = model_store[idx];
          if (cmd == CMD_POP) begin
            if (sel) model_upper--;
            else model_lower--;
          end
        end
      end
      default: begin
        // clear: count only, entries keep their contents
        if (sel) model_upper = 0;
        else model_lower = 0;
      end
    endcase
    len = sel ? model_upper : model_lower;
    r.length = len[LEN_W-1:0];
    r.is_empty = (len == 0);
    r.is_full = (model_lower + model_upper >= DEPTH);
    return r;
  endfunction

  // Sends one transaction; the expectation is formed at the accepting edge
  task automatic send_item(cmd_t cmd, logic sel, logic [WORD_W-1:0] x, logic [WORD_W-1:0] y);
    logic [IN_DATA_W-1:0] word;
    int unsigned          gap;
    word = '0;
    word[IN_CMD_LO +: 2] = cmd;
    word[IN_X_LO +: WORD_W] = x;
    word[IN_Y_LO +: WORD_W] = y;
    gap = draw_gap(tx_no_idle);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    in_tuser <= sel;
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(apply_stack_op(cmd, sel, x, y));
  endtask

  // Sender holds off until every outstanding result has been checked
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(logic [OUT_DATA_W-1:0] d);
    stack_result_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result transaction with no expectation pending: tdata %h", d);
      error_count++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (d[OUT_ST_LO +: 2] !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, d[OUT_ST_LO +: 2]);
      error_count++;
    end
    if (d[OUT_X_LO +: WORD_W] !== exp_r.x) begin
      $error("out_x: expected %0d, got %0d", $signed(exp_r.x), $signed(d[OUT_X_LO +: WORD_W]));
      error_count++;
    end
    if (d[OUT_Y_LO +: WORD_W] !== exp_r.y) begin
      $error("out_y: expected %0d, got %0d", $signed(exp_r.y), $signed(d[OUT_Y_LO +: WORD_W]));
      error_count++;
    end
    if (d[OUT_LEN_LO +: LEN_W] !== exp_r.length) begin
      $error("length: expected %0d, got %0d", exp_r.length, d[OUT_LEN_LO +: LEN_W]);
      error_count++;
    end
    if (d[OUT_EMPTY] !== exp_r.is_empty) begin
      $error("is_empty: expected %0d, got %0d", exp_r.is_empty, d[OUT_EMPTY]);
      error_count++;
    end
    if (d[OUT_FULL] !== exp_r.is_full) begin
      $error("is_full: expected %0d, got %0d", exp_r.is_full, d[OUT_FULL]);
      error_count++;
    end
  endtask

  // Receiver: checks each result transaction, then stalls a random number of cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
        rx_stall = draw_gap(rx_no_idle);
      end else if (rx_stall != 0) begin
        rx_stall--;
      end
      out_tready <= (rx_stall == 0);
    end
  end

  // Pop, peek and clear on both stacks straight out of reset
  task automatic test_empty_stacks();
    send_item(CMD_POP,   1'b0, 32'h0, 32'h0);
    send_item(CMD_PEEK,  1'b1, 32'h0, 32'h0);
    send_item(CMD_POP,   1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_PEEK,  1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_CLEAR, 1'b0, 32'h0, 32'h0);
    send_item(CMD_CLEAR, 1'b1, 32'h0, 32'h0);
    wait_for_results();
  endtask

  // Extreme words through both stacks, LIFO order, then pop past empty
  task automatic test_element_extremes();
    send_item(CMD_PUSH, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(CMD_PUSH, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_PUSH, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(CMD_PUSH, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(CMD_PUSH, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(CMD_PEEK, 1'b0, 32'h0, 32'h0);
    send_item(CMD_PEEK, 1'b1, 32'h0, 32'h0);
    send_item(CMD_POP,  1'b0, 32'h0, 32'h0);
    send_item(CMD_POP,  1'b0, 32'h0, 32'h0);
    send_item(CMD_POP,  1'b0, 32'h0, 32'h0);
    send_item(CMD_POP,  1'b0, 32'h0, 32'h0);
    send_item(CMD_POP,  1'b1, 32'h0, 32'h0);
    send_item(CMD_POP,  1'b1, 32'h0, 32'h0);
    send_item(CMD_PEEK, 1'b1, 32'h0, 32'h0);
    wait_for_results();
  endtask

  // Clear hits only the selected stack; the other keeps its top
  task automatic test_clear();
    send_item(CMD_PUSH,  1'b0, 32'h1234_5678, 32'h9ABC_DEF0);
    send_item(CMD_PUSH,  1'b0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    send_item(CMD_PUSH,  1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(CMD_CLEAR, 1'b0, 32'h0, 32'h0);
    send_item(CMD_PEEK,  1'b0, 32'h0, 32'h0);
    send_item(CMD_PEEK,  1'b1, 32'h0, 32'h0);
    send_item(CMD_CLEAR, 1'b1, 32'h0, 32'h0);
    send_item(CMD_PUSH,  1'b0, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    send_item(CMD_POP,   1'b0, 32'h0, 32'h0);
    wait_for_results();
  endtask

  // One stack takes the whole store (length reaches DEPTH), refused pushes, then clear
  task automatic test_fill_one_stack(logic sel);
    int unsigned i;
    i = 0;
    while (model_lower + model_upper < DEPTH) begin
      if (i % IDLE_SHUFFLE == 0) shuffle_idle();
      send_item(CMD_PUSH, sel, $urandom, $urandom);
      i++;
    end
    send_item(CMD_PUSH,  1'b0, $urandom, $urandom);
    send_item(CMD_PUSH,  1'b1, $urandom, $urandom);
    send_item(CMD_PEEK,  sel, $urandom, $urandom);
    send_item(CMD_POP,   ~sel, $urandom, $urandom);
    send_item(CMD_POP,   sel, $urandom, $urandom);
    send_item(CMD_PUSH,  ~sel, $urandom, $urandom);
    send_item(CMD_PUSH,  sel, $urandom, $urandom);
    send_item(CMD_CLEAR, sel, $urandom, $urandom);
    send_item(CMD_CLEAR, ~sel, $urandom, $urandom);
    wait_for_results();
  endtask

  // Both stacks grow toward each other until they meet
  task automatic test_fill_shared();
    int unsigned i;
    i = 0;
    while (model_lower + model_upper < DEPTH) begin
      if (i % IDLE_SHUFFLE == 0) shuffle_idle();
      send_item(CMD_PUSH, 1'($urandom_range(0, 1)), $urandom, $urandom);
      i++;
    end
    send_item(CMD_PUSH, 1'b0, $urandom, $urandom);
    send_item(CMD_PUSH, 1'b1, $urandom, $urandom);
    send_item(CMD_PEEK, 1'b0, $urandom, $urandom);
    send_item(CMD_PEEK, 1'b1, $urandom, $urandom);
  endtask

  // Phases with different push bias so the counts wander between empty and full
  task automatic test_random_mix();
    int unsigned phase;
    int unsigned i;
    int unsigned push_pct;
    int unsigned pick;
    cmd_t        cmd;
    for (phase = 0; phase < 6; phase++) begin
      push_pct = $urandom_range(25, 80);
      shuffle_idle();
      for (i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < push_pct) cmd = CMD_PUSH;
        else if (pick < 97) cmd = ($urandom_range(0, 2) == 0) ? CMD_PEEK : CMD_POP;
        else cmd = CMD_CLEAR;
        send_item(cmd, 1'($urandom_range(0, 1)), $urandom, $urandom);
      end
      // sender pause in the middle of the traffic
      if (phase == 2) wait_for_results();
    end
  endtask

  // Pop both stacks down to empty, then one pop past the bottom each
  task automatic test_drain();
    shuffle_idle();
    while (model_lower != 0 || model_upper != 0) begin
      if (model_lower != 0 && (model_upper == 0 || $urandom_range(0, 1) == 0))
        send_item(CMD_POP, 1'b0, $urandom, $urandom);
      else
        send_item(CMD_POP, 1'b1, $urandom, $urandom);
    end
    send_item(CMD_POP, 1'b0, $urandom, $urandom);
    send_item(CMD_POP, 1'b1, $urandom, $urandom);
  endtask

  initial begin
    // reset held low at the start, released once
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_stacks();
    test_element_extremes();
    test_clear();
    test_fill_one_stack(1'b0);
    test_fill_one_stack(1'b1);
    test_fill_shared();
    test_random_mix();
    test_drain();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("** shared_array_dual_stack_top: PASSED **");
    end else begin
      $display("** shared_array_dual_stack_top: FAILED **");
    end
    $finish;
  end

endmodule
